// ----- rtl/cvsd_pkg.sv -----
package cvsd_pkg;

  // Step register width
  localparam int unsigned STEP_W = 24;

  // Saturation limit of the step register
  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

  // Width of the integrator sum before saturation
  localparam int unsigned SUM_W = STEP_W + 3;

  // Serial multiplier length (bits of the coefficient)
  localparam int unsigned MUL_STEPS = 16;

  // Bits per code byte
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Output limits
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;

  // Register indexes
  localparam logic [2:0] REG_SYLLABIC_DECAY = 3'd0;
  localparam logic [2:0] REG_STEP_BOOST     = 3'd1;
  localparam logic [2:0] REG_STEP_FLOOR     = 3'd2;
  localparam logic [2:0] REG_INTEG_GAIN_ONE = 3'd3;
  localparam logic [2:0] REG_INTEG_GAIN_TWO = 3'd4;
  localparam logic [2:0] REG_STEP_GAIN      = 3'd5;

  // Register reset values
  localparam logic [14:0] RST_SYLLABIC_DECAY = 15'd32604;
  localparam logic [14:0] RST_STEP_BOOST     = 15'd1280;
  localparam logic [14:0] RST_STEP_FLOOR     = 15'd10;
  localparam logic [15:0] RST_INTEG_GAIN_ONE = 16'd63242;
  localparam logic [15:0] RST_INTEG_GAIN_TWO = 16'd30802;
  localparam logic [15:0] RST_STEP_GAIN      = 16'd32767;

endpackage

// ----- rtl/cvsd_decoder_top.sv -----
// CVSD decoder with syllabic companding. A code byte is accepted only while
// the decoder is idle; it yields one signed 16-bit sample per requested bit
// (bit 7 first), with last_of_byte set on the final one. Each code bit runs
// through ST_MUL_A, in which three bit-serial multipliers decay the step and
// scale both integrator taps, ST_MUL_B, in which the step multiplier is
// reused for the step gain, and ST_FINISH, which saturates the sample and
// hands it to the output register, waiting while that register holds a
// sample on a stalled output. One sample can sit in the output register
// while the next is being computed. A byte with valid_bits of zero is taken
// and produces nothing; values above eight count as eight. Configuration
// writes are always ready and must be issued while no byte is in progress.
module cvsd_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  // code byte channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         code_byte_i,
  input  logic [3:0]         valid_bits_i,
  // sample channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_o,
  output logic               last_of_byte_o,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int unsigned SW = cvsd_pkg::STEP_W;
  localparam int unsigned NW = cvsd_pkg::SUM_W;
  localparam logic [3:0] LAST_CNT = 4'(cvsd_pkg::MUL_STEPS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_FINISH
  } state_e;

  // Configuration registers
  logic [14:0] decay_q, boost_q, floor_q;
  logic [15:0] gain1_q, gain2_q, sgain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= cvsd_pkg::RST_SYLLABIC_DECAY;
      boost_q <= cvsd_pkg::RST_STEP_BOOST;
      floor_q <= cvsd_pkg::RST_STEP_FLOOR;
      gain1_q <= cvsd_pkg::RST_INTEG_GAIN_ONE;
      gain2_q <= cvsd_pkg::RST_INTEG_GAIN_TWO;
      sgain_q <= cvsd_pkg::RST_STEP_GAIN;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cvsd_pkg::REG_SYLLABIC_DECAY: decay_q <= cfg_data_i[14:0];
        cvsd_pkg::REG_STEP_BOOST:     boost_q <= cfg_data_i[14:0];
        cvsd_pkg::REG_STEP_FLOOR:     floor_q <= cfg_data_i[14:0];
        cvsd_pkg::REG_INTEG_GAIN_ONE: gain1_q <= cfg_data_i;
        cvsd_pkg::REG_INTEG_GAIN_TWO: gain2_q <= cfg_data_i;
        cvsd_pkg::REG_STEP_GAIN:      sgain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  state_e              state_q, state_d;
  logic [3:0]          cnt_q, cnt_d;
  logic [3:0]          rem_q, rem_d;
  logic [7:0]          code_q, code_d;
  logic [SW-1:0]       step_q, step_d;
  // bit history: seen flag and bit value, two deep
  logic                hv1_q, hv1_d, hv2_q, hv2_d;
  logic                hb1_q, hb1_d, hb2_q, hb2_d;
  logic signed [15:0]  oh1_q, oh1_d, oh2_q, oh2_d;
  // serial multipliers: coefficient shift registers and running high parts
  logic [15:0]         mr_s_q, mr_s_d, mr_a_q, mr_a_d, mr_b_q, mr_b_d;
  logic [SW-1:0]       hs_q, hs_d;
  logic signed [15:0]  ha_q, ha_d, hb_q, hb_d;
  // scaled terms
  logic signed [16:0]  a_q, a_d, b_q, b_d;
  logic [SW:0]         c_q, c_d;
  // output register
  logic                out_valid_q, out_valid_d, last_q, last_d;
  logic signed [15:0]  sample_q, sample_d;

  logic                cur;
  logic                agree;
  logic [SW:0]         s_sum;
  logic signed [16:0]  a_sum, b_sum;
  logic [SW+1:0]       nstep;
  logic [SW-1:0]       step_sat;
  logic [14:0]         inc;
  logic signed [NW-1:0] c_ext, sum;
  logic signed [15:0]  res;
  logic                out_free;
  logic [3:0]          in_cnt;

  assign cur = code_q[7];
  assign agree = hv1_q & hv2_q & (hb1_q == cur) & (hb2_q == cur);
  assign inc = agree ? boost_q : floor_q;

  // one coefficient bit per cycle on each multiplier
  assign s_sum = {1'b0, hs_q} + (mr_s_q[0] ? {1'b0, step_q} : '0);
  assign a_sum = {ha_q[15], ha_q} + (mr_a_q[0] ? {oh1_q[15], oh1_q} : 17'sd0);
  assign b_sum = {hb_q[15], hb_q} + (mr_b_q[0] ? {oh2_q[15], oh2_q} : 17'sd0);

  // decayed step plus increment, saturated
  assign nstep = {1'b0, s_sum} + (SW+2)'(inc);
  assign step_sat = (nstep > (SW+2)'(cvsd_pkg::STEP_MAX)) ? cvsd_pkg::STEP_MAX
                                                          : nstep[SW-1:0];

  // integrator sum and output saturation
  assign c_ext = signed'({2'b00, c_q});
  assign sum = NW'(a_q) - NW'(b_q) + (cur ? c_ext : -c_ext);
  always_comb begin
    if (sum >= NW'(cvsd_pkg::SAMPLE_MAX)) begin
      res = cvsd_pkg::SAMPLE_MAX;
    end else if (sum <= NW'(cvsd_pkg::SAMPLE_MIN)) begin
      res = cvsd_pkg::SAMPLE_MIN;
    end else begin
      res = sum[15:0];
    end
  end

  assign in_cnt = (valid_bits_i > cvsd_pkg::BITS_PER_BYTE) ? cvsd_pkg::BITS_PER_BYTE
                                                           : valid_bits_i;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    code_d      = code_q;
    step_d      = step_q;
    hv1_d       = hv1_q;
    hv2_d       = hv2_q;
    hb1_d       = hb1_q;
    hb2_d       = hb2_q;
    oh1_d       = oh1_q;
    oh2_d       = oh2_q;
    mr_s_d      = mr_s_q;
    mr_a_d      = mr_a_q;
    mr_b_d      = mr_b_q;
    hs_d        = hs_q;
    ha_d        = ha_q;
    hb_d        = hb_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    out_valid_d = out_valid_q;
    last_d      = last_q;
    sample_d    = sample_q;

    // output transfer frees the register
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_cnt != 4'd0)) begin
          code_d  = code_byte_i;
          rem_d   = in_cnt;
          state_d = ST_MUL_A;
        end
      end
      // decay product and both integrator taps
      ST_MUL_A: begin
        mr_s_d = mr_s_q >> 1;
        mr_a_d = mr_a_q >> 1;
        mr_b_d = mr_b_q >> 1;
        hs_d   = s_sum[SW:1];
        ha_d   = a_sum[16:1];
        hb_d   = b_sum[16:1];
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == LAST_CNT) begin
          step_d  = step_sat;
          a_d     = a_sum;
          b_d     = b_sum;
          mr_s_d  = sgain_q;
          hs_d    = '0;
          state_d = ST_MUL_B;
        end
      end
      // step gain on the new step
      ST_MUL_B: begin
        mr_s_d = mr_s_q >> 1;
        hs_d   = s_sum[SW:1];
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == LAST_CNT) begin
          c_d     = s_sum;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          sample_d    = res;
          last_d      = (rem_q == 4'd1);
          hv2_d       = hv1_q;
          hb2_d       = hb1_q;
          hv1_d       = 1'b1;
          hb1_d       = cur;
          oh2_d       = oh1_q;
          oh1_d       = res;
          code_d      = {code_q[6:0], 1'b0};
          rem_d       = rem_q - 4'd1;
          state_d     = (rem_q == 4'd1) ? ST_IDLE : ST_MUL_A;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // multiplier load at the start of every code bit
    if ((state_q != ST_MUL_A) && (state_d == ST_MUL_A)) begin
      mr_s_d = {1'b0, decay_q};
      mr_a_d = gain1_q;
      mr_b_d = gain2_q;
      hs_d   = '0;
      ha_d   = '0;
      hb_d   = '0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      code_q      <= '0;
      step_q      <= '0;
      hv1_q       <= 1'b0;
      hv2_q       <= 1'b0;
      hb1_q       <= 1'b0;
      hb2_q       <= 1'b0;
      oh1_q       <= '0;
      oh2_q       <= '0;
      mr_s_q      <= '0;
      mr_a_q      <= '0;
      mr_b_q      <= '0;
      hs_q        <= '0;
      ha_q        <= '0;
      hb_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      sample_q    <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      code_q      <= code_d;
      step_q      <= step_d;
      hv1_q       <= hv1_d;
      hv2_q       <= hv2_d;
      hb1_q       <= hb1_d;
      hb2_q       <= hb2_d;
      oh1_q       <= oh1_d;
      oh2_q       <= oh2_d;
      mr_s_q      <= mr_s_d;
      mr_a_q      <= mr_a_d;
      mr_b_q      <= mr_b_d;
      hs_q        <= hs_d;
      ha_q        <= ha_d;
      hb_q        <= hb_d;
      a_q         <= a_d;
      b_q         <= b_d;
      c_q         <= c_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      sample_q    <= sample_d;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign sample_o       = sample_q;
  assign last_of_byte_o = last_q;

`ifndef SYNTH
  // a byte in progress always has bits left
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (rem_q != 4'd0))
    else $error("busy with no bits remaining");

  // the last sample of a byte returns the decoder to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free && rem_q == 4'd1) |=> (state_q == ST_IDLE))
    else $error("decoder not idle after last sample");

  // the step gain multiply starts from its first coefficient bit
  a_mul_b_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_B && $past(state_q) == ST_MUL_A) |-> (cnt_q == 4'd0))
    else $error("step gain multiply misaligned");

  // a new sample is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && state_q == ST_FINISH) |=> (state_q == ST_FINISH))
    else $error("sample written over a pending one");
`endif

endmodule
